// ----- design/lfpd_pkg.sv -----
// Shared types, constants and the sensor pattern map for the line follower PD motor drive.
package lfpd_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int GAIN_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_KP_GAIN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KD_GAIN = 8'd1;

   localparam logic [6:0] PAT_CENTER     = 7'b0001000;
   localparam logic [6:0] PAT_RIGHT_1    = 7'b0001100;
   localparam logic [6:0] PAT_RIGHT_3    = 7'b0000100;
   localparam logic [6:0] PAT_RIGHT_4    = 7'b0000110;
   localparam logic [6:0] PAT_RIGHT_10   = 7'b0000010;
   localparam logic [6:0] PAT_LEFT_1     = 7'b0011000;
   localparam logic [6:0] PAT_LEFT_3     = 7'b0010000;
   localparam logic [6:0] PAT_LEFT_4     = 7'b0110000;
   localparam logic [6:0] PAT_LEFT_10    = 7'b0100000;

   localparam logic signed [17:0] CMD_MAX = 18'sd1023;
   localparam logic signed [17:0] CMD_MIN = -18'sd1023;

   typedef struct packed {
      logic signed [4:0]  err;
      logic signed [5:0]  delta;
      logic signed [10:0] base;
   } stage_type;

   typedef struct packed {
      logic [9:0] right_duty;
      logic       right_dir_a;
      logic       right_dir_b;
      logic [9:0] left_duty;
      logic       left_dir_a;
      logic       left_dir_b;
   } result_type;

   function automatic logic signed [4:0] map_position(logic [6:0] pattern,
                                                      logic signed [4:0] held);
      logic signed [4:0] pos;
      case (pattern)
         PAT_CENTER:   pos = 5'sd0;
         PAT_RIGHT_1:  pos = 5'sd1;
         PAT_RIGHT_3:  pos = 5'sd3;
         PAT_RIGHT_4:  pos = 5'sd4;
         PAT_RIGHT_10: pos = 5'sd10;
         PAT_LEFT_1:   pos = -5'sd1;
         PAT_LEFT_3:   pos = -5'sd3;
         PAT_LEFT_4:   pos = -5'sd4;
         PAT_LEFT_10:  pos = -5'sd10;
         default:      pos = held;
      endcase
      return pos;
   endfunction

endpackage

// ----- design/lfpd_if.sv -----
// Valid/ready channel interfaces for samples, wheel commands and register writes.
interface lfpd_req_if;
   logic              valid;
   logic              ready;
   logic [6:0]        line_pattern;
   logic signed [10:0] base_speed;

   modport source (output valid, output line_pattern, output base_speed, input ready);
   modport sink   (input valid, input line_pattern, input base_speed, output ready);
endinterface

interface lfpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] right_duty;
   logic       right_dir_a;
   logic       right_dir_b;
   logic [9:0] left_duty;
   logic       left_dir_a;
   logic       left_dir_b;

   modport source (output valid, output right_duty, output right_dir_a, output right_dir_b,
                   output left_duty, output left_dir_a, output left_dir_b, input ready);
   modport sink   (input valid, input right_duty, input right_dir_a, input right_dir_b,
                   input left_duty, input left_dir_a, input left_dir_b, output ready);
endinterface

interface lfpd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lfpd_pkg::CSR_INDEX_W-1:0] index;
   logic [lfpd_pkg::GAIN_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/lfpd_track.sv -----
// Line position tracking, error and error delta, registered into the input stage.
module lfpd_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [6:0]          line_pattern,
   input  logic signed [10:0]  base_speed,
   output lfpd_pkg::stage_type stage_ff
);

   logic signed [4:0] held_position_ff;
   logic signed [4:0] held_position_in;
   logic signed [4:0] previous_error_ff;
   logic signed [4:0] err_in;
   lfpd_pkg::stage_type stage_in;

   always_comb begin
      held_position_in = lfpd_pkg::map_position(line_pattern, held_position_ff);
      err_in           = -held_position_in;
      stage_in.err     = err_in;
      stage_in.delta   = 6'(err_in) - 6'(previous_error_ff);
      stage_in.base    = base_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_position_ff  <= '0;
         previous_error_ff <= '0;
      end else if (load) begin
         held_position_ff  <= held_position_in;
         previous_error_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ----- design/lfpd_drive.sv -----
// PD correction, wheel mixing, truncation, saturation and the result register.
module lfpd_drive (
   input  logic                          clock,
   input  logic                          load,
   input  lfpd_pkg::stage_type           stage,
   input  logic [lfpd_pkg::GAIN_W-1:0]   kp_gain,
   input  logic [lfpd_pkg::GAIN_W-1:0]   kd_gain,
   output lfpd_pkg::result_type          result_ff
);

   logic signed [16:0] kp_s;
   logic signed [16:0] kd_s;
   logic signed [23:0] p_term;
   logic signed [23:0] d_term;
   logic signed [25:0] corr;
   logic signed [25:0] base_q;
   logic signed [25:0] right_q;
   logic signed [25:0] left_q;
   logic signed [17:0] right_cmd;
   logic signed [17:0] left_cmd;
   lfpd_pkg::result_type result_in;

   function automatic logic signed [17:0] to_command(logic signed [25:0] q);
      logic signed [17:0] c;
      c = q[25:8];
      if (q[25] && (q[7:0] != 8'd0)) begin
         c = c + 18'sd1;
      end
      if (c > lfpd_pkg::CMD_MAX) begin
         c = lfpd_pkg::CMD_MAX;
      end else if (c < lfpd_pkg::CMD_MIN) begin
         c = lfpd_pkg::CMD_MIN;
      end
      return c;
   endfunction

   function automatic logic [9:0] magnitude(logic signed [17:0] c);
      logic signed [17:0] m;
      m = c[17] ? -c : c;
      return m[9:0];
   endfunction

   always_comb begin
      kp_s    = signed'({1'b0, kp_gain});
      kd_s    = signed'({1'b0, kd_gain});
      p_term  = 24'(kp_s) * 24'(stage.err);
      d_term  = 24'(kd_s) * 24'(stage.delta);
      corr    = 26'(p_term) + 26'(d_term);
      base_q  = signed'({{7{stage.base[10]}}, stage.base, 8'd0});
      right_q = base_q + corr;
      left_q  = base_q - corr;

      right_cmd = to_command(right_q);
      left_cmd  = to_command(left_q);

      result_in.right_duty  = magnitude(right_cmd);
      result_in.right_dir_a = right_cmd[17];
      result_in.right_dir_b = !right_cmd[17] && (right_cmd != 18'sd0);
      result_in.left_duty   = magnitude(left_cmd);
      result_in.left_dir_a  = !left_cmd[17] && (left_cmd != 18'sd0);
      result_in.left_dir_b  = left_cmd[17];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

// ----- design/line_follower_pd_motor_drive.sv -----
// Top level of the line follower PD motor drive: handshake, gain registers and stages.
//
// req carries one control sample per transfer: the 7-bit sensor pattern and a
// signed base speed. rsp carries one wheel command set per sample: duty
// magnitude and H-bridge direction bits for the right and left wheels.
// csr writes the gains: index 0 is kp_gain, index 1 is kd_gain, both unsigned
// Q8.8; writes to other indexes are dropped. csr is always ready.
// The req transfer edge loads the input stage register with the sensor map and
// error update; the result register then loads the PD multiply, wheel mix and
// saturation on an edge where it is free (rsp empty or rsp ready), and rsp valid
// rises with that load. Throughput is one sample per cycle while the receiver
// does not stall.
// When the receiver stalls, the result register holds and the input stage can
// still take one more sample; req ready drops only when both are full.
// Reset clears both stage valid flags, the held line position, the previous
// error and both gains.
module line_follower_pd_motor_drive (
   input  logic      clock,
   input  logic      reset,
   lfpd_req_if.sink  req,
   lfpd_rsp_if.source rsp,
   lfpd_csr_if.sink  csr
);

   logic [lfpd_pkg::GAIN_W-1:0] kp_gain_ff;
   logic [lfpd_pkg::GAIN_W-1:0] kd_gain_ff;
   logic                        stage_valid_ff;
   logic                        stage_valid_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        out_free;
   logic                        req_xfer;
   logic                        advance;
   lfpd_pkg::stage_type         stage;
   lfpd_pkg::result_type        result;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff <= '0;
         kd_gain_ff <= '0;
      end else if (csr.valid) begin
         if (csr.index == lfpd_pkg::CSR_KP_GAIN) begin
            kp_gain_ff <= csr.data;
         end
         if (csr.index == lfpd_pkg::CSR_KD_GAIN) begin
            kd_gain_ff <= csr.data;
         end
      end
   end

   always_comb begin
      out_free       = !rsp_valid_ff || rsp.ready;
      advance        = stage_valid_ff && out_free;
      req.ready      = !stage_valid_ff || out_free;
      req_xfer       = req.valid && req.ready;
      stage_valid_in = req_xfer || (stage_valid_ff && !out_free);
      rsp_valid_in   = advance || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   lfpd_track u_track (
      .clock        (clock),
      .reset        (reset),
      .load         (req_xfer),
      .line_pattern (req.line_pattern),
      .base_speed   (req.base_speed),
      .stage_ff     (stage)
   );

   lfpd_drive u_drive (
      .clock     (clock),
      .load      (advance),
      .stage     (stage),
      .kp_gain   (kp_gain_ff),
      .kd_gain   (kd_gain_ff),
      .result_ff (result)
   );

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.right_duty  = result.right_duty;
   assign rsp.right_dir_a = result.right_dir_a;
   assign rsp.right_dir_b = result.right_dir_b;
   assign rsp.left_duty   = result.left_duty;
   assign rsp.left_dir_a  = result.left_dir_a;
   assign rsp.left_dir_b  = result.left_dir_b;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the line follower PD motor drive: wheel commands predicted per sample.
module tb;
   import lfpd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_SAMPLES = 210;
   localparam int PHASE_COUNT   = 8;
   localparam int REPORT_LINES  = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 8'hFF;

   localparam logic signed [10:0] BASE_TOP = 11'sd1023;
   localparam logic signed [10:0] BASE_MIN = 11'sh400;

   typedef struct packed {
      logic [6:0]         pattern;
      logic signed [10:0] base;
   } sensor_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfpd_req_if req_ch ();
   lfpd_rsp_if rsp_ch ();
   lfpd_csr_if csr_ch ();

   line_follower_pd_motor_drive dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   sensor_sample_type  pending_samples[$];
   result_type         expected_wheels[$];
   sensor_sample_type  next_sample;
   result_type         wanted;
   string              diffs;
   logic [GAIN_W-1:0]  kp_gain, kd_gain;
   logic [GAIN_W-1:0]  kp_next, kd_next;
   logic signed [4:0]  line_position, last_error;
   int                 sender_idle_pct, receiver_idle_pct;
   int                 samples_issued, results_checked, mismatch_count, cycle_count;
   int                 phase;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clamp_command(longint q88);
      longint c;
      c = q88 / 256;
      if (c > CMD_MAX) c = CMD_MAX;
      if (c < CMD_MIN) c = CMD_MIN;
      return c;
   endfunction

   function automatic result_type predict_wheels(logic [6:0] pattern,
                                                 logic signed [10:0] base);
      int         err_now, err_step;
      longint     corr, right, left;
      result_type r;
      case (pattern)
         PAT_CENTER:   line_position = 5'sd0;
         PAT_RIGHT_1:  line_position = 5'sd1;
         PAT_RIGHT_3:  line_position = 5'sd3;
         PAT_RIGHT_4:  line_position = 5'sd4;
         PAT_RIGHT_10: line_position = 5'sd10;
         PAT_LEFT_1:   line_position = -5'sd1;
         PAT_LEFT_3:   line_position = -5'sd3;
         PAT_LEFT_4:   line_position = -5'sd4;
         PAT_LEFT_10:  line_position = -5'sd10;
         default:      ;
      endcase
      err_now  = -int'(line_position);
      err_step = err_now - int'(last_error);
      corr     = longint'(kp_gain) * err_now + longint'(kd_gain) * err_step;
      right    = clamp_command(longint'(base) * 256 + corr);
      left     = clamp_command(longint'(base) * 256 - corr);
      r.right_duty  = 10'(right < 0 ? -right : right);
      r.right_dir_a = right < 0;
      r.right_dir_b = right > 0;
      r.left_duty   = 10'(left < 0 ? -left : left);
      r.left_dir_a  = left > 0;
      r.left_dir_b  = left < 0;
      last_error = 5'(err_now);
      return r;
   endfunction

   function automatic sensor_sample_type random_sample();
      sensor_sample_type s;
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 8))
            0:       s.pattern = PAT_CENTER;
            1:       s.pattern = PAT_RIGHT_1;
            2:       s.pattern = PAT_RIGHT_3;
            3:       s.pattern = PAT_RIGHT_4;
            4:       s.pattern = PAT_RIGHT_10;
            5:       s.pattern = PAT_LEFT_1;
            6:       s.pattern = PAT_LEFT_3;
            7:       s.pattern = PAT_LEFT_4;
            default: s.pattern = PAT_LEFT_10;
         endcase
      end else begin
         s.pattern = 7'($urandom_range(0, 127));
      end
      case ($urandom_range(0, 15))
         0:       s.base = BASE_MIN;
         1:       s.base = BASE_TOP;
         2:       s.base = -BASE_TOP;
         3:       s.base = 11'(int'($urandom_range(0, 16)) - 8);
         default: s.base = 11'(int'($urandom_range(0, 2046)) - 1023);
      endcase
      return s;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < REPORT_LINES)
         $display("ERROR cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic queue_sample(logic [6:0] pattern, logic signed [10:0] base);
      sensor_sample_type s;
      s.pattern = pattern;
      s.base    = base;
      pending_samples.push_back(s);
      samples_issued++;
   endtask

   task automatic write_gain(logic [CSR_INDEX_W-1:0] index, logic [GAIN_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (index == CSR_KP_GAIN) kp_gain = value;
      else if (index == CSR_KD_GAIN) kd_gain = value;
   endtask

   task automatic set_gains(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] kd);
      write_gain(CSR_KP_GAIN, kp);
      write_gain(CSR_KD_GAIN, kd);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (results_checked != samples_issued) @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("line_follower_pd_motor_drive test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_wheels.push_back(predict_wheels(req_ch.line_pattern, req_ch.base_speed));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_sample = pending_samples.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.line_pattern <= next_sample.pattern;
               req_ch.base_speed   <= next_sample.base;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_wheels.size() == 0) begin
               report_mismatch("wheel command transfer with no sample pending");
            end else begin
               wanted = expected_wheels.pop_front();
               diffs = "";
               if (rsp_ch.right_duty !== wanted.right_duty)
                  diffs = {diffs, $sformatf(" right_duty %0d/%0d",
                                            rsp_ch.right_duty, wanted.right_duty)};
               if (rsp_ch.right_dir_a !== wanted.right_dir_a)
                  diffs = {diffs, $sformatf(" right_dir_a %b/%b",
                                            rsp_ch.right_dir_a, wanted.right_dir_a)};
               if (rsp_ch.right_dir_b !== wanted.right_dir_b)
                  diffs = {diffs, $sformatf(" right_dir_b %b/%b",
                                            rsp_ch.right_dir_b, wanted.right_dir_b)};
               if (rsp_ch.left_duty !== wanted.left_duty)
                  diffs = {diffs, $sformatf(" left_duty %0d/%0d",
                                            rsp_ch.left_duty, wanted.left_duty)};
               if (rsp_ch.left_dir_a !== wanted.left_dir_a)
                  diffs = {diffs, $sformatf(" left_dir_a %b/%b",
                                            rsp_ch.left_dir_a, wanted.left_dir_a)};
               if (rsp_ch.left_dir_b !== wanted.left_dir_b)
                  diffs = {diffs, $sformatf(" left_dir_b %b/%b",
                                            rsp_ch.left_dir_b, wanted.left_dir_b)};
               if (diffs != "")
                  report_mismatch({"wheel command (got/want):", diffs});
            end
            results_checked++;
         end
         rsp_ch.ready <= $urandom_range(0, 99) >= receiver_idle_pct;
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.line_pattern = '0;
      req_ch.base_speed   = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      kp_gain             = '0;
      kd_gain             = '0;
      line_position       = '0;
      last_error          = '0;
      sender_idle_pct     = 0;
      receiver_idle_pct   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_sample(PAT_CENTER, 11'sd0);
      queue_sample(7'h7F, BASE_TOP);
      queue_sample(7'h00, -BASE_TOP);
      queue_sample(PAT_LEFT_10, BASE_MIN);
      wait_drained();

      set_gains(16'h0080, 16'h0100);
      queue_sample(PAT_RIGHT_1, 11'sd0);
      queue_sample(PAT_RIGHT_1, 11'sd0);
      queue_sample(7'b0000001, 11'sd1);
      queue_sample(7'b1000000, -11'sd1);
      queue_sample(PAT_RIGHT_3, 11'sd512);
      queue_sample(PAT_RIGHT_4, -11'sd512);
      queue_sample(PAT_RIGHT_10, BASE_TOP);
      queue_sample(PAT_LEFT_1, -BASE_TOP);
      queue_sample(PAT_LEFT_3, BASE_MIN);
      queue_sample(PAT_LEFT_4, 11'sd100);
      queue_sample(PAT_LEFT_10, -11'sd100);
      queue_sample(PAT_CENTER, 11'sd0);
      queue_sample(7'h2A, BASE_TOP);
      queue_sample(7'h55, BASE_MIN);
      queue_sample(7'h7F, 11'sd0);
      queue_sample(7'h00, 11'sd0);
      wait_drained();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin kp_next = 16'hFFFF; kd_next = 16'hFFFF; end
            1: begin kp_next = 16'h0000; kd_next = 16'hFFFF; end
            2: begin kp_next = 16'hFFFF; kd_next = 16'h0000; end
            3: begin kp_next = 16'h0000; kd_next = 16'h0000; end
            6: begin
               kp_next = 16'($urandom_range(0, 16'hFFFF));
               kd_next = 16'($urandom_range(0, 16'hFFFF));
            end
            default: begin
               kp_next = 16'($urandom_range(0, 16'h0800));
               kd_next = 16'($urandom_range(0, 16'h0800));
            end
         endcase
         if (phase == 4) begin
            write_gain(CSR_SPARE_HI, 16'hFFFF);
            write_gain(CSR_SPARE_LO, 16'($urandom_range(0, 16'hFFFF)));
         end
         set_gains(kp_next, kd_next);
         if (phase < 3) begin
            sender_idle_pct   = 30;
            receiver_idle_pct = 85;
         end else if (phase < 6) begin
            sender_idle_pct   = 85;
            receiver_idle_pct = 30;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         for (int i = 0; i < PHASE_SAMPLES; i++) begin
            next_sample = random_sample();
            queue_sample(next_sample.pattern, next_sample.base);
            // hold the sender until the pipeline has drained
            if (phase == 5 && i == PHASE_SAMPLES / 2)
               wait_drained();
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (expected_wheels.size() != 0)
         report_mismatch($sformatf("%0d wheel commands never arrived", expected_wheels.size()));
      if (mismatch_count == 0) begin
         $display("line_follower_pd_motor_drive test passed");
      end else begin
         $display("line_follower_pd_motor_drive test failed");
      end
      $finish;
   end

endmodule
